FILE: rtl/core/mlwh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-lane word hash package
// Shared widths, constants, types and the per-lane mixing function.
// ----------------------------------------------------------------------------
package mlwh_pkg;

	// Field widths
	localparam int WORD_W = 64;
	localparam int IDX_W  = 4;
	localparam int CFG_W  = 5;

	// Default and upper bound of the lane count
	localparam int MAX_LANES_DEF = 16;

	// Hash constants
	localparam logic [WORD_W-1:0] HASH_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [WORD_W-1:0] LANE_STEP  = 64'h9E37_79B9_7F4A_7C15;
	localparam int ROT_LEFT   = 31;
	localparam int FOLD_SHIFT = 33;

	// Reset value of the lane count register
	localparam logic [CFG_W-1:0] LANE_COUNT_RST = 5'd1;

	// Input item commands
	localparam logic CMD_ABSORB = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	// Control that the sequencer hands to every lane cell.
	typedef struct packed {
		logic absorb;
		logic finish;
		logic shift;
	} cell_ctl_t;

	// One slot of the digest shift chain.
	typedef struct packed {
		logic [WORD_W-1:0] digest;
		logic [IDX_W-1:0]  idx;
	} slot_t;

	// Starting value of a lane; only evaluated on constants.
	function automatic logic [WORD_W-1:0] lane_init(input int unsigned lane);
		logic [WORD_W-1:0] prod;
		prod = WORD_W'(64'(lane) * LANE_STEP);
		return HASH_BASIS ^ prod;
	endfunction

	// One absorb step: xor, multiply by 0x100000001B3, rotate, fold.
	// The prime is 2^40 + 0x1B3, so the product is a short shift-add sum.
	function automatic logic [WORD_W-1:0] mix_word(input logic [WORD_W-1:0] h,
	                                               input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] p;
		logic [WORD_W-1:0] r;
		x = h ^ w;
		p = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
		r = (p << ROT_LEFT) | (p >> (WORD_W - ROT_LEFT));
		return r ^ (r >> FOLD_SHIFT);
	endfunction

endpackage

FILE: rtl/core/mlwh_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-lane word hash lane cell
// Holds one running lane hash and one slot of the digest shift chain.
// ----------------------------------------------------------------------------
module mlwh_cell #(
	parameter int unsigned LANE = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  mlwh_pkg::cell_ctl_t       ctl,
	input  logic [mlwh_pkg::WORD_W-1:0] word,
	input  mlwh_pkg::slot_t           slot_in,
	output mlwh_pkg::slot_t           slot_out
);
	import mlwh_pkg::*;

	localparam logic [WORD_W-1:0] SEED = lane_init(LANE);

	logic [WORD_W-1:0] hash_q;
	slot_t             slot_q;

	// Running hash: reseed on finish, mix in the word on absorb.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= SEED;
		end else if (ctl.finish) begin
			hash_q <= SEED;
		end else if (ctl.absorb) begin
			hash_q <= mix_word(hash_q, word);
		end
	end

	// Digest slot: load this lane's hash on finish, else take the neighbor's.
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			slot_q.digest <= hash_q;
			slot_q.idx    <= IDX_W'(LANE);
		end else if (ctl.shift) begin
			slot_q <= slot_in;
		end
	end

	assign slot_out = slot_q;

endmodule

FILE: rtl/core/mlwh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-lane word hash sequencer
// Lane count register, handshakes and the count of digest items to send.
// ----------------------------------------------------------------------------
module mlwh_ctrl #(
	parameter int unsigned MAX_LANES = mlwh_pkg::MAX_LANES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [mlwh_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	input  logic                       cmd,
	output logic                       in_ready,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       last,
	output mlwh_pkg::cell_ctl_t        ctl
);
	import mlwh_pkg::*;

	localparam int CNT_W = $clog2(MAX_LANES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_LANES);
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	logic [CFG_W-1:0] lane_count_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] active;
	logic             drain_ok;
	logic             in_take;
	logic             out_take;

	// Lane count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_count_q <= LANE_COUNT_RST;
		end else if (cfg_we) begin
			lane_count_q <= cfg_data;
		end
	end

	// Active lanes: zero counts as one, anything above the lane total is clamped.
	always_comb begin
		if (lane_count_q == '0) begin
			active = CNT_ONE;
		end else if (lane_count_q > CFG_W'(MAX_LANES)) begin
			active = CNT_MAX;
		end else begin
			active = CNT_W'(lane_count_q);
		end
	end

	// Handshakes. A finish waits until the previous digest is out of the chain,
	// or its final item leaves in this same cycle.
	always_comb begin
		out_valid  = (cnt_q != '0);
		out_take   = out_valid && out_ready;
		drain_ok   = (cnt_q == '0) || ((cnt_q == CNT_ONE) && out_ready);
		in_ready   = (cmd == CMD_ABSORB) || drain_ok;
		in_take    = in_valid && in_ready;
		ctl.absorb = in_take && (cmd == CMD_ABSORB);
		ctl.finish = in_take && (cmd == CMD_FINISH);
		ctl.shift  = out_take;
		last       = (cnt_q == CNT_ONE);
	end

	// Digest items still to deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.finish) begin
			cnt_q <= active;
		end else if (out_take) begin
			cnt_q <= cnt_q - CNT_ONE;
		end
	end

	// The count never exceeds the number of lanes.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("digest count above lane total");

	// Absorb and finish never happen together.
	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.absorb && ctl.finish))
		else $error("absorb and finish in one cycle");

	// A finish always leaves at least one digest item pending.
	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.finish |=> (cnt_q != '0))
		else $error("finish did not load the digest count");

	// While more than one item is pending, each delivery drops the count by one.
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && (cnt_q > CNT_ONE)) |=> (cnt_q == $past(cnt_q) - CNT_ONE))
		else $error("digest count did not step down");

endmodule

FILE: rtl/core/multi_lane_word_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-lane word hash
// Running 64-bit hash in up to 16 lanes over a stream of message words.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+--------------------------------
//  in      | in        | in_valid / in_ready  | cmd, data_word
//  out     | out       | out_valid / out_ready| digest_word, lane_index, last
//  cfg     | in        | cfg_we               | cfg_data (lane count)
//
//  An absorb item is taken every cycle; every lane cell mixes the word into its
//  hash (xor, constant multiply, rotate, fold).
//  A finish copies all lane hashes into the cell chain and reseeds the lanes
//  together; the digest then shifts out one item per cycle toward cell 0
//  while out_ready is high. Absorbs continue while a digest drains; a second
//  finish waits until the chain's final item leaves.
//  Reset seeds every lane at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module multi_lane_word_hash_top #(
	parameter int unsigned MAX_LANES = mlwh_pkg::MAX_LANES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [mlwh_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [mlwh_pkg::WORD_W-1:0] data_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mlwh_pkg::WORD_W-1:0] digest_word,
	output logic [mlwh_pkg::IDX_W-1:0]  lane_index,
	output logic                        last
);
	import mlwh_pkg::*;

	cell_ctl_t ctl;
	slot_t     slot_w [MAX_LANES];

	// Sequencer and lane count register.
	mlwh_ctrl #(
		.MAX_LANES(MAX_LANES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.cmd      (cmd),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.last     (last),
		.ctl      (ctl)
	);

	// Row of lane cells; digest slots shift from the high lane toward lane 0.
	for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
		slot_t nbr;
		if (i == MAX_LANES - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = slot_w[i+1];
		end

		mlwh_cell #(
			.LANE(i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.word    (data_word),
			.slot_in (nbr),
			.slot_out(slot_w[i])
		);
	end

	// Result item comes from the head of the chain.
	assign digest_word = slot_w[0].digest;
	assign lane_index  = slot_w[0].idx;

endmodule
